>>> design/aeg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeg_pkg
// Shared types and constants of the AHDSR envelope generator.
// ----------------------------------------------------------------------------
package aeg_pkg;

    localparam int FRAC_BITS   = 22;
    localparam int ONE_Q22     = 4194304;
    localparam int SILENCE_LSB = 32;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int MODE_BITS     = 2;
    localparam int PEAK_BITS     = 23;
    localparam int OUT_LEVEL_BITS = 24;
    localparam int IN_TDATA_BITS  = 24;
    localparam int OUT_TDATA_BITS = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_BITS-1:0] REG_SUSTAIN_LEVEL = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HOLD_SAMPLES  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ATTACK_COEF   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ATTACK_BASE   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DECAY_COEF    = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DECAY_BASE    = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RELEASE_COEF  = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RELEASE_BASE  = 3'd7;

    // Item kinds carried on tuser
    localparam logic [MODE_BITS-1:0] MODE_TICK     = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_NOTE_ON  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_NOTE_OFF = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_HOLD    = 3'd2,
        PH_DECAY   = 3'd3,
        PH_SUSTAIN = 3'd4,
        PH_RELEASE = 3'd5
    } phase_t;

    typedef struct packed {
        logic        [22:0] sustain_level;
        logic        [22:0] hold_samples;
        logic        [22:0] attack_coef;
        logic        [22:0] attack_base;
        logic        [22:0] decay_coef;
        logic signed [23:0] decay_base;
        logic        [22:0] release_coef;
        logic signed [23:0] release_base;
    } cfg_t;

    // Levels and coefficients above 1.0 act as 1.0
    function automatic logic [22:0] clamp_one(input logic [22:0] v);
        logic [22:0] r;
        r = (v > 23'(ONE_Q22)) ? 23'(ONE_Q22) : v;
        return r;
    endfunction

endpackage

>>> design/aeg_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeg_cfg_regs
// Configuration register file; levels and coefficients are clamped on write.
// ----------------------------------------------------------------------------
module aeg_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [aeg_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [aeg_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output aeg_pkg::cfg_t                     cfg
);
    import aeg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SUSTAIN_LEVEL: cfg_next.sustain_level = clamp_one(cfg_wdata[22:0]);
                REG_HOLD_SAMPLES:  cfg_next.hold_samples  = cfg_wdata[22:0];
                REG_ATTACK_COEF:   cfg_next.attack_coef   = clamp_one(cfg_wdata[22:0]);
                REG_ATTACK_BASE:   cfg_next.attack_base   = cfg_wdata[22:0];
                REG_DECAY_COEF:    cfg_next.decay_coef    = clamp_one(cfg_wdata[22:0]);
                REG_DECAY_BASE:    cfg_next.decay_base    = $signed(cfg_wdata);
                REG_RELEASE_COEF:  cfg_next.release_coef  = clamp_one(cfg_wdata[22:0]);
                REG_RELEASE_BASE:  cfg_next.release_base  = $signed(cfg_wdata);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sustain_level <= 23'(ONE_Q22);
            cfg_reg.hold_samples  <= 23'd480;
            cfg_reg.attack_coef   <= '0;
            cfg_reg.attack_base   <= 23'(ONE_Q22);
            cfg_reg.decay_coef    <= '0;
            cfg_reg.decay_base    <= 24'(ONE_Q22);
            cfg_reg.release_coef  <= '0;
            cfg_reg.release_base  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/aeg_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeg_step
// Next-state logic for one item: one shared multiply-add, saturation and
// the phase transitions.
// ----------------------------------------------------------------------------
module aeg_step #(
    parameter int LEVEL_BITS = 24,
    parameter int HOLD_BITS  = 24
)
(
    input  logic [aeg_pkg::MODE_BITS-1:0]  mode,
    input  logic [aeg_pkg::PEAK_BITS-1:0]  peak_in,
    input  aeg_pkg::cfg_t                  cfg,
    input  aeg_pkg::phase_t                phase_cur,
    input  logic signed [LEVEL_BITS-1:0]   level_cur,
    input  logic [HOLD_BITS-1:0]           hold_cur,
    input  logic [aeg_pkg::PEAK_BITS-1:0]  peak_cur,
    input  logic signed [LEVEL_BITS-1:0]   step_cur,
    output aeg_pkg::phase_t                phase_nxt,
    output logic signed [LEVEL_BITS-1:0]   level_nxt,
    output logic [HOLD_BITS-1:0]           hold_nxt,
    output logic [aeg_pkg::PEAK_BITS-1:0]  peak_nxt,
    output logic signed [LEVEL_BITS-1:0]   step_nxt
);
    import aeg_pkg::*;

    localparam int AW  = (LEVEL_BITS > 24) ? LEVEL_BITS : 24;
    localparam int PW  = AW + 24;
    localparam int SW  = AW + 3;
    localparam int HCW = (HOLD_BITS > 23) ? HOLD_BITS : 23;

    localparam logic signed [SW-1:0] SAT_HI =
        {{(SW-LEVEL_BITS+1){1'b0}}, {(LEVEL_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO =
        {{(SW-LEVEL_BITS+1){1'b1}}, {(LEVEL_BITS-1){1'b0}}};
    localparam logic signed [SW-1:0] SIL_POS = SW'(SILENCE_LSB);
    localparam logic signed [SW-1:0] SIL_NEG = -SW'(SILENCE_LSB);
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'd2097152);
    localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;

    function automatic logic signed [LEVEL_BITS-1:0] sat_l(input logic signed [SW-1:0] v);
        logic signed [LEVEL_BITS-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[LEVEL_BITS-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[LEVEL_BITS-1:0];
        else
            r = v[LEVEL_BITS-1:0];
        return r;
    endfunction

    logic signed [SW-1:0]         peak_ext;
    logic signed [SW-1:0]         sus_ext;
    logic signed [LEVEL_BITS-1:0] peak_sat;
    logic signed [LEVEL_BITS-1:0] sus_sat;
    logic                         sus_zero;
    logic                         attack_live;

    logic signed [AW-1:0]         mul_a;
    logic signed [23:0]           mul_c;
    logic signed [AW-1:0]         add_b;
    logic signed [PW-1:0]         prod;
    logic signed [PW-1:0]         prod_rnd;
    logic signed [PW-1:0]         prod_shr;
    logic signed [AW+1:0]         prod_q;
    logic signed [SW-1:0]         mac_sum;
    logic signed [LEVEL_BITS-1:0] mac;
    logic signed [SW-1:0]         mac_ext;
    logic signed [SW-1:0]         sus_diff;

    logic [HOLD_BITS-1:0]         hold_base;
    logic [HOLD_BITS-1:0]         hold_inc;
    logic                         hold_run;
    phase_t                       sus_phase;
    phase_t                       dec_phase;
    logic signed [LEVEL_BITS-1:0] dec_level;

    assign peak_ext    = SW'($signed({1'b0, peak_cur}));
    assign sus_ext     = SW'($signed({1'b0, cfg.sustain_level}));
    assign peak_sat    = sat_l(peak_ext);
    assign sus_sat     = sat_l(sus_ext);
    assign sus_zero    = (cfg.sustain_level == '0);
    assign attack_live = (phase_cur == PH_ATTACK) && (cfg.attack_coef != '0);

    // Operand select for the shared multiply-add
    always_comb
    begin
        if (mode == MODE_NOTE_ON)
        begin
            mul_a = AW'($signed({1'b0, cfg.attack_base}));
            mul_c = $signed({1'b0, peak_in});
            add_b = '0;
        end
        else if (attack_live)
        begin
            mul_a = AW'(level_cur);
            mul_c = $signed({1'b0, cfg.attack_coef});
            add_b = AW'(step_cur);
        end
        else if (phase_cur == PH_RELEASE)
        begin
            mul_a = AW'(level_cur);
            mul_c = $signed({1'b0, cfg.release_coef});
            add_b = AW'($signed(cfg.release_base));
        end
        else
        begin
            // instant attack enters decay from the peak
            mul_a = (phase_cur == PH_ATTACK) ? AW'(peak_sat) : AW'(level_cur);
            mul_c = $signed({1'b0, cfg.decay_coef});
            add_b = AW'($signed(cfg.decay_base));
        end
    end

    assign prod     = PW'(mul_a) * PW'(mul_c);
    assign prod_rnd = prod + ROUND_HALF;
    assign prod_shr = prod_rnd >>> FRAC_BITS;
    assign prod_q   = prod_shr[AW+1:0];
    assign mac_sum  = SW'(add_b) + SW'(prod_q);
    assign mac      = sat_l(mac_sum);
    assign mac_ext  = SW'(mac);
    assign sus_diff = mac_ext - sus_ext;

    // Hold count, restarted from zero on an instant attack
    assign hold_base = (phase_cur == PH_ATTACK) ? '0 : hold_cur;
    assign hold_inc  = (hold_base == HOLD_MAX) ? hold_base : hold_base + 1'b1;
    assign hold_run  = HCW'(hold_inc) < HCW'(cfg.hold_samples);

    assign sus_phase = sus_zero ? PH_IDLE : PH_SUSTAIN;

    always_comb
    begin
        if (cfg.decay_coef != '0)
        begin
            dec_level = mac;
            dec_phase = ((sus_diff > SIL_NEG) && (sus_diff < SIL_POS)) ? sus_phase : PH_DECAY;
        end
        else
        begin
            dec_level = sus_sat;
            dec_phase = sus_phase;
        end
    end

    always_comb
    begin
        phase_nxt = phase_cur;
        level_nxt = level_cur;
        hold_nxt  = hold_cur;
        peak_nxt  = peak_cur;
        step_nxt  = step_cur;
        case (mode)
            MODE_TICK:
            begin
                unique case (phase_cur) inside
                    PH_ATTACK, PH_HOLD:
                    begin
                        if (attack_live)
                        begin
                            level_nxt = mac;
                            if (peak_ext > sus_ext)
                            begin
                                if (mac_ext >= peak_ext)
                                begin
                                    level_nxt = peak_sat;
                                    hold_nxt  = '0;
                                    phase_nxt = PH_HOLD;
                                end
                            end
                            else if (mac_ext >= sus_ext)
                            begin
                                level_nxt = sus_sat;
                                phase_nxt = PH_SUSTAIN;
                            end
                        end
                        else
                        begin
                            hold_nxt = hold_inc;
                            if (hold_run)
                            begin
                                level_nxt = peak_sat;
                                phase_nxt = PH_HOLD;
                            end
                            else
                            begin
                                level_nxt = dec_level;
                                phase_nxt = dec_phase;
                            end
                        end
                    end
                    PH_DECAY:
                    begin
                        level_nxt = dec_level;
                        phase_nxt = dec_phase;
                    end
                    PH_SUSTAIN:
                    begin
                        level_nxt = sus_sat;
                    end
                    PH_RELEASE:
                    begin
                        if ((cfg.release_coef == '0) || ((mac_ext > SIL_NEG) && (mac_ext < SIL_POS)))
                        begin
                            level_nxt = '0;
                            phase_nxt = PH_IDLE;
                        end
                        else
                        begin
                            level_nxt = mac;
                        end
                    end
                    default:
                    begin
                        phase_nxt = phase_cur;
                    end
                endcase
            end
            MODE_NOTE_ON:
            begin
                peak_nxt  = peak_in;
                step_nxt  = mac;
                phase_nxt = PH_ATTACK;
            end
            MODE_NOTE_OFF:
            begin
                if (phase_cur != PH_IDLE)
                    phase_nxt = PH_RELEASE;
            end
            default:
            begin
                phase_nxt = phase_cur;
            end
        endcase
    end

endmodule

>>> design/ahdsr_envelope_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdsr_envelope_generator
// One-voice AHDSR envelope: sample ticks, note-on and note-off in, the
// level and phase after each item out.
// The input item waits in an input register; when the output register is free
// or drains, the result is loaded into it and offered on the output.
// Throughput: one item per cycle while the output is not stalled; the level
// feedback closes through one combinational multiply-add.
// Reset: idle, level 0, peak 1.0, registers at their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module ahdsr_envelope_generator #(
    parameter int LEVEL_BITS = 24,
    parameter int HOLD_BITS  = 24
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aeg_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [aeg_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [aeg_pkg::IN_TDATA_BITS-1:0]   s_tdata,  // [22:0] peak_level
    input  logic [aeg_pkg::MODE_BITS-1:0]       s_tuser,  // [1:0] mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [aeg_pkg::OUT_TDATA_BITS-1:0]  m_tdata   // [23:0] level, [26:24] phase,
                                                          // [27] busy_res
);
    import aeg_pkg::*;

    localparam logic signed [LEVEL_BITS-1:0] STEP_RESET =
        (LEVEL_BITS > 23) ? LEVEL_BITS'(ONE_Q22) : {1'b0, {(LEVEL_BITS-1){1'b1}}};

    cfg_t cfg;

    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic [MODE_BITS-1:0]         in_mode_reg;
    logic [PEAK_BITS-1:0]         in_peak_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [OUT_LEVEL_BITS-1:0]    out_level_reg;
    phase_t                       out_phase_reg;
    logic                         out_busy_reg;

    phase_t                       phase_reg;
    phase_t                       phase_next;
    logic signed [LEVEL_BITS-1:0] level_reg;
    logic signed [LEVEL_BITS-1:0] level_next;
    logic [HOLD_BITS-1:0]         hold_reg;
    logic [HOLD_BITS-1:0]         hold_next;
    logic [PEAK_BITS-1:0]         peak_reg;
    logic [PEAK_BITS-1:0]         peak_next;
    logic signed [LEVEL_BITS-1:0] step_reg;
    logic signed [LEVEL_BITS-1:0] step_next;

    logic                         s_xfer;
    logic                         advance;
    logic signed [LEVEL_BITS+OUT_LEVEL_BITS-1:0] level_wide;

    aeg_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    aeg_step #(
        .LEVEL_BITS (LEVEL_BITS),
        .HOLD_BITS  (HOLD_BITS)
    ) u_step
    (
        .mode      (in_mode_reg),
        .peak_in   (in_peak_reg),
        .cfg       (cfg),
        .phase_cur (phase_reg),
        .level_cur (level_reg),
        .hold_cur  (hold_reg),
        .peak_cur  (peak_reg),
        .step_cur  (step_reg),
        .phase_nxt (phase_next),
        .level_nxt (level_next),
        .hold_nxt  (hold_next),
        .peak_nxt  (peak_next),
        .step_nxt  (step_next)
    );

    // Retire the held item whenever the output register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign in_valid_next  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    assign level_wide = (LEVEL_BITS + OUT_LEVEL_BITS)'(level_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            level_reg     <= '0;
            hold_reg      <= '0;
            peak_reg      <= PEAK_BITS'(ONE_Q22);
            step_reg      <= STEP_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                level_reg <= level_next;
                hold_reg  <= hold_next;
                peak_reg  <= peak_next;
                step_reg  <= step_next;
            end
        end
    end

    // Payload registers: hold the input item, capture the result on advance
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_mode_reg <= s_tuser;
            in_peak_reg <= s_tdata[PEAK_BITS-1:0];
        end
        if (advance)
        begin
            out_level_reg <= level_wide[OUT_LEVEL_BITS-1:0];
            out_phase_reg <= phase_next;
            out_busy_reg  <= (phase_reg != PH_IDLE);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_busy_reg, out_phase_reg, out_level_reg};

endmodule
